@@ hdl/grayscale_region_convert_core_assert.svh @@
// Assertion macros for the grayscale region converter.
// Both macros expect a clock named i_clk; GRC_ASSERT also expects an active-low reset named i_rst_n.
`ifndef GRAYSCALE_REGION_CONVERT_CORE_ASSERT_SVH
`define GRAYSCALE_REGION_CONVERT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define GRC_ASSERT(lbl, prop, msg)
`define GRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/grc_pkg.sv @@
package grc_pkg;

    localparam int COORD_BITS     = 12;
    localparam int CHAN_BITS      = 8;
    localparam int COLOR_BITS     = 32;
    localparam int MODE_BITS      = 4;
    localparam int CFG_INDEX_BITS = 3;

    // Fixed-point reciprocals: floor(v * n / d) == (v * K) >> RECIP_SHIFT for
    // K = ceil(n * 2^RECIP_SHIFT / d), exact as long as 2^RECIP_SHIFT exceeds
    // the largest operand times d.
    localparam int          RECIP_SHIFT = 24;
    localparam logic [63:0] RECIP_ONE   = 64'd1 << RECIP_SHIFT;

    localparam logic [RECIP_SHIFT-1:0] K_MEAN  = RECIP_SHIFT'((RECIP_ONE + 64'd2) / 64'd3);
    localparam logic [RECIP_SHIFT-1:0] K_PER_R =
        RECIP_SHIFT'((64'd30 * RECIP_ONE + 64'd99) / 64'd100);
    localparam logic [RECIP_SHIFT-1:0] K_PER_G =
        RECIP_SHIFT'((64'd59 * RECIP_ONE + 64'd99) / 64'd100);
    localparam logic [RECIP_SHIFT-1:0] K_PER_B =
        RECIP_SHIFT'((64'd11 * RECIP_ONE + 64'd99) / 64'd100);
    localparam logic [RECIP_SHIFT-1:0] K_601_R =
        RECIP_SHIFT'((64'd299 * RECIP_ONE + 64'd999) / 64'd1000);
    localparam logic [RECIP_SHIFT-1:0] K_601_G =
        RECIP_SHIFT'((64'd587 * RECIP_ONE + 64'd999) / 64'd1000);
    localparam logic [RECIP_SHIFT-1:0] K_601_B =
        RECIP_SHIFT'((64'd114 * RECIP_ONE + 64'd999) / 64'd1000);
    localparam logic [RECIP_SHIFT-1:0] K_709_R =
        RECIP_SHIFT'((64'd2126 * RECIP_ONE + 64'd9999) / 64'd10000);
    localparam logic [RECIP_SHIFT-1:0] K_709_G =
        RECIP_SHIFT'((64'd7152 * RECIP_ONE + 64'd9999) / 64'd10000);
    localparam logic [RECIP_SHIFT-1:0] K_709_B =
        RECIP_SHIFT'((64'd722 * RECIP_ONE + 64'd9999) / 64'd10000);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_MEAN       = 4'd0,
        MODE_BRIGHTNESS = 4'd1,
        MODE_PERCEPTUAL = 4'd2,
        MODE_RED        = 4'd3,
        MODE_GREEN      = 4'd4,
        MODE_BLUE       = 4'd5,
        MODE_CYAN       = 4'd6,
        MODE_MAGENTA    = 4'd7,
        MODE_YELLOW     = 4'd8,
        MODE_ALPHA      = 4'd9,
        MODE_BT601      = 4'd10,
        MODE_BT709      = 4'd11,
        MODE_DESAT      = 4'd12,
        MODE_MAX        = 4'd13,
        MODE_MIN        = 4'd14,
        MODE_RESERVED   = 4'd15
    } t_gray_mode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRAY_MODE     = 3'd0,
        REG_COPY_OUTSIDE  = 3'd1,
        REG_REGION_LEFT   = 3'd2,
        REG_REGION_TOP    = 3'd3,
        REG_REGION_RIGHT  = 3'd4,
        REG_REGION_BOTTOM = 3'd5,
        REG_FILL_COLOR    = 3'd6
    } t_cfg_index;

    typedef struct packed {
        t_gray_mode              gray_mode;
        logic                    copy_outside;
        logic [COORD_BITS-1:0]   region_left;
        logic [COORD_BITS-1:0]   region_top;
        logic [COORD_BITS-1:0]   region_right;
        logic [COORD_BITS-1:0]   region_bottom;
        logic [COLOR_BITS-1:0]   fill_color;
    } t_cfg;

    // Scales an 8-bit value by a reciprocal constant and keeps the integer part.
    function automatic logic [CHAN_BITS-1:0] scale8(input logic [CHAN_BITS-1:0] v,
                                                    input logic [RECIP_SHIFT-1:0] k);
        logic [RECIP_SHIFT+CHAN_BITS-1:0] p;
        begin
            p = {{RECIP_SHIFT{1'b0}}, v} * {{CHAN_BITS{1'b0}}, k};
            return p[RECIP_SHIFT+CHAN_BITS-1:RECIP_SHIFT];
        end
    endfunction

    // Same for a 10-bit sum; the caller guarantees the quotient fits 8 bits.
    function automatic logic [CHAN_BITS-1:0] scale10(input logic [CHAN_BITS+1:0] v,
                                                     input logic [RECIP_SHIFT-1:0] k);
        logic [RECIP_SHIFT+CHAN_BITS+1:0] p;
        begin
            p = {{RECIP_SHIFT{1'b0}}, v} * {{(CHAN_BITS+2){1'b0}}, k};
            return p[RECIP_SHIFT+CHAN_BITS-1:RECIP_SHIFT];
        end
    endfunction

endpackage

@@ hdl/grayscale_region_convert_core.sv @@
// Grayscale region converter: one ARGB pixel beat with its column and row goes in
// on the input channel (i_in_valid / o_in_stall), one result beat comes out on the
// output channel (o_out_valid / i_out_stall). A beat moves on a rising edge where
// valid is high and stall is low.
// Pixels inside the configured rectangle become gray with alpha kept; pixels
// outside pass unchanged or are replaced by the fill color. An unsupported gray
// mode zeroes the pixel and raises o_mode_error.
// Configuration is a separate write channel (i_cfg_valid / o_cfg_ready, index
// and data); o_cfg_ready is always high and writes belong in idle periods only.
// An accepted input beat waits in the input register and moves into the result
// register once that register is empty or being drained. Throughput is one
// pixel per clock while the receiver does not stall, set by the single
// conversion stage between the input register and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register fills; o_in_stall rises only when both are full and the receiver
// still stalls, so no cycle is lost once the stall drops.
// Synchronous active-low reset empties both registers and restores the
// configuration defaults (mean mode, copy outside, full-frame rectangle).
`include "grayscale_region_convert_core_assert.svh"

module grayscale_region_convert_core
    import grc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [COLOR_BITS-1:0]     i_cfg_data,
    // pixel input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [COORD_BITS-1:0]     i_column,
    input  logic [COORD_BITS-1:0]     i_row,
    input  logic [CHAN_BITS-1:0]      i_in_alpha,
    input  logic [CHAN_BITS-1:0]      i_in_red,
    input  logic [CHAN_BITS-1:0]      i_in_green,
    input  logic [CHAN_BITS-1:0]      i_in_blue,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CHAN_BITS-1:0]      o_out_alpha,
    output logic [CHAN_BITS-1:0]      o_out_red,
    output logic [CHAN_BITS-1:0]      o_out_green,
    output logic [CHAN_BITS-1:0]      o_out_blue,
    output logic                      o_mode_error
);

    t_cfg cfg;

    grc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // Input register.
    logic                  r_s1_valid;
    logic                  n_s1_valid;
    logic [COORD_BITS-1:0] r_column;
    logic [COORD_BITS-1:0] r_row;
    logic [CHAN_BITS-1:0]  r_alpha;
    logic [CHAN_BITS-1:0]  r_red;
    logic [CHAN_BITS-1:0]  r_green;
    logic [CHAN_BITS-1:0]  r_blue;

    // Result register.
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [CHAN_BITS-1:0]  r_out_alpha;
    logic [CHAN_BITS-1:0]  r_out_red;
    logic [CHAN_BITS-1:0]  r_out_green;
    logic [CHAN_BITS-1:0]  r_out_blue;
    logic                  r_mode_error;
    logic [CHAN_BITS-1:0]  n_out_alpha;
    logic [CHAN_BITS-1:0]  n_out_red;
    logic [CHAN_BITS-1:0]  n_out_green;
    logic [CHAN_BITS-1:0]  n_out_blue;

    logic                  s1_load;
    logic                  s2_load;
    logic                  in_region;
    logic [CHAN_BITS-1:0]  gray;
    logic                  gray_error;

    // The result register takes a new beat whenever it is empty or being drained;
    // the input register is blocked only when its beat cannot move forward.
    assign s2_load    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s2_load;
    assign s1_load    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s2_load) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s2_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    grc_gray_calc u_gray_calc (
        .i_mode       (cfg.gray_mode),
        .i_alpha      (r_alpha),
        .i_red        (r_red),
        .i_green      (r_green),
        .i_blue       (r_blue),
        .o_gray       (gray),
        .o_mode_error (gray_error)
    );

    // An empty rectangle (left past right or top past bottom) simply never matches.
    assign in_region = (r_column >= cfg.region_left) && (r_column <= cfg.region_right) &&
                       (r_row >= cfg.region_top) && (r_row <= cfg.region_bottom);

    always_comb begin
        if (gray_error) begin
            n_out_alpha = '0;
            n_out_red   = '0;
            n_out_green = '0;
            n_out_blue  = '0;
        end else if (in_region) begin
            n_out_alpha = r_alpha;
            n_out_red   = gray;
            n_out_green = gray;
            n_out_blue  = gray;
        end else if (cfg.copy_outside) begin
            n_out_alpha = r_alpha;
            n_out_red   = r_red;
            n_out_green = r_green;
            n_out_blue  = r_blue;
        end else begin
            n_out_alpha = cfg.fill_color[4*CHAN_BITS-1:3*CHAN_BITS];
            n_out_red   = cfg.fill_color[3*CHAN_BITS-1:2*CHAN_BITS];
            n_out_green = cfg.fill_color[2*CHAN_BITS-1:CHAN_BITS];
            n_out_blue  = cfg.fill_color[CHAN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_column <= i_column;
            r_row    <= i_row;
            r_alpha  <= i_in_alpha;
            r_red    <= i_in_red;
            r_green  <= i_in_green;
            r_blue   <= i_in_blue;
        end
        if (s2_load) begin
            r_out_alpha  <= n_out_alpha;
            r_out_red    <= n_out_red;
            r_out_green  <= n_out_green;
            r_out_blue   <= n_out_blue;
            r_mode_error <= gray_error;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_alpha  = r_out_alpha;
    assign o_out_red    = r_out_red;
    assign o_out_green  = r_out_green;
    assign o_out_blue   = r_out_blue;
    assign o_mode_error = r_mode_error;

    `GRC_ASSERT(a_stall_only_when_full,
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall),
        "input stalled while the pipeline could advance")
    `GRC_ASSERT(a_error_pixel_zero,
        (o_out_valid && o_mode_error) |->
            (o_out_alpha == '0 && o_out_red == '0 && o_out_green == '0 && o_out_blue == '0),
        "mode error beat carries a nonzero pixel")
    `GRC_ASSERT(a_free_slot_advances,
        (r_s1_valid && !r_out_valid) |=> o_out_valid,
        "pending beat did not reach the empty result register")
    `GRC_ASSERT_ALWAYS(a_empty_after_reset,
        $rose(i_rst_n) |-> (!o_out_valid && !r_s1_valid),
        "pipeline not empty after reset")

endmodule

@@ hdl/grc_cfg_regs.sv @@
module grc_cfg_regs
    import grc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [COLOR_BITS-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                REG_GRAY_MODE:     n_cfg.gray_mode     = t_gray_mode'(i_cfg_data[MODE_BITS-1:0]);
                REG_COPY_OUTSIDE:  n_cfg.copy_outside  = i_cfg_data[0];
                REG_REGION_LEFT:   n_cfg.region_left   = i_cfg_data[COORD_BITS-1:0];
                REG_REGION_TOP:    n_cfg.region_top    = i_cfg_data[COORD_BITS-1:0];
                REG_REGION_RIGHT:  n_cfg.region_right  = i_cfg_data[COORD_BITS-1:0];
                REG_REGION_BOTTOM: n_cfg.region_bottom = i_cfg_data[COORD_BITS-1:0];
                REG_FILL_COLOR:    n_cfg.fill_color    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_mode     <= MODE_MEAN;
            r_cfg.copy_outside  <= 1'b1;
            r_cfg.region_left   <= '0;
            r_cfg.region_top    <= '0;
            r_cfg.region_right  <= '1;
            r_cfg.region_bottom <= '1;
            r_cfg.fill_color    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/grc_gray_calc.sv @@
module grc_gray_calc
    import grc_pkg::*;
(
    input  t_gray_mode           i_mode,
    input  logic [CHAN_BITS-1:0] i_alpha,
    input  logic [CHAN_BITS-1:0] i_red,
    input  logic [CHAN_BITS-1:0] i_green,
    input  logic [CHAN_BITS-1:0] i_blue,
    output logic [CHAN_BITS-1:0] o_gray,
    output logic                 o_mode_error
);

    logic [CHAN_BITS-1:0] max_rg;
    logic [CHAN_BITS-1:0] min_rg;
    logic [CHAN_BITS-1:0] max_rgb;
    logic [CHAN_BITS-1:0] min_rgb;
    logic [CHAN_BITS+1:0] sum_rgb;
    logic [CHAN_BITS:0]   sum_gb;
    logic [CHAN_BITS:0]   sum_rb;
    logic [CHAN_BITS:0]   sum_rg;
    logic [CHAN_BITS:0]   sum_mm;
    logic [CHAN_BITS+1:0] per_sum;
    logic [CHAN_BITS+1:0] bt601_sum;
    logic [CHAN_BITS+1:0] bt709_sum;

    assign max_rg  = (i_red > i_green) ? i_red : i_green;
    assign min_rg  = (i_red < i_green) ? i_red : i_green;
    assign max_rgb = (max_rg > i_blue) ? max_rg : i_blue;
    assign min_rgb = (min_rg < i_blue) ? min_rg : i_blue;

    assign sum_rgb = {2'b00, i_red} + {2'b00, i_green} + {2'b00, i_blue};
    assign sum_gb  = {1'b0, i_green} + {1'b0, i_blue};
    assign sum_rb  = {1'b0, i_red} + {1'b0, i_blue};
    assign sum_rg  = {1'b0, i_red} + {1'b0, i_green};
    assign sum_mm  = {1'b0, max_rgb} + {1'b0, min_rgb};

    // Each weighted term is truncated on its own before the terms are added.
    assign per_sum   = {2'b00, scale8(i_red, K_PER_R)} + {2'b00, scale8(i_green, K_PER_G)}
                     + {2'b00, scale8(i_blue, K_PER_B)};
    assign bt601_sum = {2'b00, scale8(i_red, K_601_R)} + {2'b00, scale8(i_green, K_601_G)}
                     + {2'b00, scale8(i_blue, K_601_B)};
    assign bt709_sum = {2'b00, scale8(i_red, K_709_R)} + {2'b00, scale8(i_green, K_709_G)}
                     + {2'b00, scale8(i_blue, K_709_B)};

    always_comb begin
        o_mode_error = 1'b0;
        case (i_mode)
            MODE_MEAN:       o_gray = scale10(sum_rgb, K_MEAN);
            MODE_PERCEPTUAL: o_gray = per_sum[CHAN_BITS-1:0];
            MODE_RED:        o_gray = i_red;
            MODE_GREEN:      o_gray = i_green;
            MODE_BLUE:       o_gray = i_blue;
            MODE_CYAN:       o_gray = sum_gb[CHAN_BITS:1];
            MODE_MAGENTA:    o_gray = sum_rb[CHAN_BITS:1];
            MODE_YELLOW:     o_gray = sum_rg[CHAN_BITS:1];
            MODE_ALPHA:      o_gray = i_alpha;
            MODE_BT601:      o_gray = bt601_sum[CHAN_BITS-1:0];
            MODE_BT709:      o_gray = bt709_sum[CHAN_BITS-1:0];
            MODE_DESAT:      o_gray = sum_mm[CHAN_BITS:1];
            MODE_MAX:        o_gray = max_rgb;
            MODE_MIN:        o_gray = min_rgb;
            default: begin
                o_gray       = '0;
                o_mode_error = 1'b1;
            end
        endcase
    end

endmodule
